/* sv/assert_macros.svh */
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock out of reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)

`endif

`endif

/* sv/wfrm_pkg.sv */
// widths, codes and state type of the windowed frame rate meter
`timescale 1ns / 1ps
`default_nettype none

package wfrm_pkg;

    // fixed field widths
    localparam int TPS_W     = 30;
    localparam int FRAME_W   = 24;
    localparam int RATE_W    = 24;
    localparam int COUNT_W   = 32;
    localparam int FRAC_BITS = 8;

    // configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_IDX_W  = CFG_ADDR_W - 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TPS = '0;

    localparam logic [TPS_W-1:0]  TPS_RESET = 30'd1000000;
    localparam logic [RATE_W-1:0] RATE_MAX  = '1;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOAD   = 4'b0010,
        ST_DIV    = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

endpackage

`default_nettype wire

/* sv/wfrm_ifs.sv */
// valid/ready channels for frame durations and rate results
`timescale 1ns / 1ps
`default_nettype none

interface wfrm_in_if import wfrm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FRAME_W-1:0] frame_ticks;

    modport source (output valid, output frame_ticks, input ready);
    modport sink   (input valid, input frame_ticks, output ready);
endinterface

interface wfrm_out_if import wfrm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [RATE_W-1:0]  frame_rate;
    logic [COUNT_W-1:0] frame_count;

    modport source (output valid, output frame_rate, output frame_count, input ready);
    modport sink   (input valid, input frame_rate, input frame_count, output ready);
endinterface

`default_nettype wire

/* sv/wfrm_div.sv */
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module wfrm_div import wfrm_pkg::*; #(
    parameter int NUM_W = 45,
    parameter int DEN_W = 30
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] numer,
    input  wire logic [DEN_W-1:0] denom,
    output logic                  done,
    output logic [NUM_W-1:0]      quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             fits;

    // one shift-compare-subtract step
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[NUM_W-1]};
        fits    = (rem_sh >= {1'b0, den_reg});
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    // step control
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // datapath next values
    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (start)
        begin
            quo_next = numer;
            rem_next = '0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NUM_W-2:0], fits};
            rem_next = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= denom;
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

`default_nettype wire

/* sv/windowed_frame_rate_meter.sv */
// top level: ring store of frame durations, running sum and rate divider
// an accepted word passes through the load, divide and finish states into the result word register
// the divider, NUM_W bits wide, works on one word at a time: no new word is taken until it is done
// (NUM_W = 38 + clog2(WINDOW_DEPTH + 1)); a new word is taken while a result waits in the output register
// reset: async, active low; sum, slot, frame count cleared, ticks_per_second = 1000000
// the store has no clearing pass: a fill flag makes unwritten slots read as zero
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module windowed_frame_rate_meter import wfrm_pkg::*; #(
    parameter int WINDOW_DEPTH  = 64,
    parameter int DURATION_BITS = 24
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    wfrm_in_if.sink                    frame_in,
    wfrm_out_if.source                 rate_out,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int DUR_W   = (DURATION_BITS < FRAME_W) ? DURATION_BITS : FRAME_W;
    localparam int SLOT_W  = $clog2(WINDOW_DEPTH);
    localparam int SUM_W   = DUR_W + $clog2(WINDOW_DEPTH);
    localparam int DEPTH_W = $clog2(WINDOW_DEPTH + 1);
    localparam int PROD_W  = TPS_W + DEPTH_W;
    localparam int NUM_W   = PROD_W + FRAC_BITS;

    state_t state_reg, state_next;

    logic [TPS_W-1:0]   tps_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               filled_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [COUNT_W-1:0] count_reg;
    logic [DUR_W-1:0]   dur_reg;
    logic [DUR_W-1:0]   rd_data_reg;
    logic [DUR_W-1:0]   old_dur;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  tps_ext;

    logic               out_valid_reg;
    logic [RATE_W-1:0]  rate_reg;
    logic [COUNT_W-1:0] count_out_reg;
    logic [RATE_W-1:0]  rate_next;

    logic               in_take;
    logic               out_free;
    logic               cfg_wr;
    logic               div_start;
    logic               div_done;
    logic [NUM_W-1:0]   div_quot;

    logic [DUR_W-1:0]   store_mem [WINDOW_DEPTH];

    // handshakes
    assign frame_in.ready = (state_reg == ST_IDLE);
    assign in_take        = frame_in.valid && frame_in.ready;
    assign out_free       = !out_valid_reg || rate_out.ready;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[CFG_ADDR_W-1:2] == REG_TPS);
    assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_TPS) ? CFG_DATA_W'(tps_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg <= TPS_RESET;
        end
        else if (cfg_wr)
        begin
            tps_reg <= pwdata[TPS_W-1:0];
        end
    end

    // ring store: read at accept, write back in the load cycle
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            rd_data_reg <= store_mem[slot_reg];
        end
        if (state_reg == ST_LOAD)
        begin
            store_mem[slot_reg] <= dur_reg;
        end
    end

    // running sum update, unwritten slots count as zero
    always_comb
    begin
        old_dur  = filled_reg ? rd_data_reg : '0;
        sum_next = sum_reg - SUM_W'(old_dur) + SUM_W'(dur_reg);
    end

    assign div_start = (state_reg == ST_LOAD);
    assign tps_ext   = PROD_W'(tps_reg);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // window state and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            slot_reg   <= '0;
            filled_reg <= 1'b0;
            sum_reg    <= '0;
            count_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_LOAD)
            begin
                sum_reg   <= sum_next;
                count_reg <= count_reg + 1'b1;
                if (slot_reg == SLOT_W'(WINDOW_DEPTH - 1))
                begin
                    slot_reg   <= '0;
                    filled_reg <= 1'b1;
                end
                else
                begin
                    slot_reg <= slot_reg + 1'b1;
                end
            end
        end
    end

    // accepted duration and scaled numerator
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            dur_reg  <= frame_in.frame_ticks[DUR_W-1:0];
            prod_reg <= tps_ext * PROD_W'(WINDOW_DEPTH);
        end
    end

    wfrm_div #(
        .NUM_W (NUM_W),
        .DEN_W (SUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer ({prod_reg, {FRAC_BITS{1'b0}}}),
        .denom (sum_next),
        .done  (div_done),
        .quot  (div_quot)
    );

    // empty window gives zero, large quotients saturate
    always_comb
    begin
        if (sum_reg == '0)
        begin
            rate_next = '0;
        end
        else if (|div_quot[NUM_W-1:RATE_W])
        begin
            rate_next = RATE_MAX;
        end
        else
        begin
            rate_next = div_quot[RATE_W-1:0];
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_FINISH && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rate_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FINISH && out_free)
        begin
            rate_reg      <= rate_next;
            count_out_reg <= count_reg;
        end
    end

    assign rate_out.valid       = out_valid_reg;
    assign rate_out.frame_rate  = rate_reg;
    assign rate_out.frame_count = count_out_reg;

    // checks
    `ASSERT_IMPLIES(a_done_in_div, div_done, state_reg == ST_DIV, "divider done outside divide")
    `ASSERT_ALWAYS(a_valid_from_finish, $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH), "result word without finish")
    `ASSERT_ALWAYS(a_count_step, (state_reg == ST_LOAD) |=> (count_reg == $past(count_reg) + 1'b1), "frame count did not advance")
    `ASSERT_IMPLIES(a_slot_empty, !filled_reg && (state_reg == ST_IDLE), sum_reg != '0 || slot_reg == '0 || count_reg != '0, "window sum lost before first wrap")

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// self-checking bench for the windowed frame rate meter: directed table, then random bursts
`timescale 1ns / 1ps

module tb_top;
    import wfrm_pkg::*;

    localparam int WINDOW_DEPTH    = 64;
    localparam int CLK_HALF        = 5;
    localparam int DRAIN_CYCLES    = 60;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int ITEMS_PER_PHASE = 170;
    localparam int LONG_HOLD       = 400;

    localparam logic [CFG_IDX_W-1:0]  REG_SPARE  = REG_TPS + 1'b1;
    localparam logic [CFG_ADDR_W-1:0] ADDR_TPS   = {REG_TPS, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE = {REG_SPARE, 2'b00};

    typedef struct packed {
        logic [RATE_W-1:0]  rate;
        logic [COUNT_W-1:0] count;
    } rate_word_t;

    typedef struct packed {
        logic [FRAME_W-1:0] ticks;
        logic               typed;
        logic [RATE_W-1:0]  rate;
    } frame_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    wfrm_in_if  frame_if ();
    wfrm_out_if rate_if ();

    // expected rate model: ring of durations, running total, frame counter
    logic [FRAME_W-1:0] dur_ring [WINDOW_DEPTH];
    logic [TPS_W:0]     ring_total;
    int unsigned        ring_slot;
    logic [COUNT_W-1:0] frames_done;
    logic [TPS_W-1:0]   tps_now;
    rate_word_t         pending_rates [$];
    int                 errors = 0;

    // directed words at the reset tick rate; typed rates are empty window and saturation
    frame_row_t directed_rows [16] = '{
        '{24'd0,        1'b1, 24'd0},
        '{24'd0,        1'b1, 24'd0},
        '{24'd1,        1'b1, RATE_MAX},
        '{24'd0,        1'b1, RATE_MAX},
        '{24'hFFFFFF,   1'b0, 24'd0},
        '{24'hFFFFFF,   1'b0, 24'd0},
        '{24'h800000,   1'b0, 24'd0},
        '{24'h7FFFFF,   1'b0, 24'd0},
        '{24'hAAAAAA,   1'b0, 24'd0},
        '{24'h555555,   1'b0, 24'd0},
        '{24'd16667,    1'b0, 24'd0},
        '{24'd16666,    1'b0, 24'd0},
        '{24'd33333,    1'b0, 24'd0},
        '{24'd3,        1'b0, 24'd0},
        '{24'd1,        1'b0, 24'd0},
        '{24'd1000,     1'b0, 24'd0}
    };

    // tick rates per phase: min, max, zero, masked upper bits, random, typical, reset value
    logic [CFG_DATA_W-1:0] tps_plan [7] = '{
        32'd1, 32'd1000000000, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd60000, 32'd1000000
    };

    always #(CLK_HALF) clk = ~clk;

    windowed_frame_rate_meter #(
        .WINDOW_DEPTH  (WINDOW_DEPTH),
        .DURATION_BITS (FRAME_W)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .frame_in (frame_if),
        .rate_out (rate_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // push one duration into the window and work out the rate word it gives
    function automatic rate_word_t advance_window(input logic [FRAME_W-1:0] ticks);
        rate_word_t  w;
        logic [63:0] numer;
        logic [63:0] quot;
        ring_total          = ring_total - dur_ring[ring_slot] + ticks;
        dur_ring[ring_slot] = ticks;
        ring_slot           = (ring_slot + 1) % WINDOW_DEPTH;
        frames_done         = frames_done + 1'b1;
        quot                = '0;
        if (ring_total != '0)
        begin
            numer = 64'(tps_now) * WINDOW_DEPTH * (64'd1 << FRAC_BITS);
            quot  = numer / 64'(ring_total);
            if (quot > 64'(RATE_MAX))
                quot = 64'(RATE_MAX);
        end
        w.rate  = quot[RATE_W-1:0];
        w.count = frames_done;
        return w;
    endfunction

    // offer one duration word, record its expected rate once taken, then idle gap cycles
    task automatic send_frame(input logic [FRAME_W-1:0] ticks, input logic typed,
                              input logic [RATE_W-1:0] typed_rate, input int gap);
        rate_word_t w;
        frame_if.valid       <= 1'b1;
        frame_if.frame_ticks <= ticks;
        do @(posedge clk); while (!frame_if.ready);
        w = advance_window(ticks);
        if (typed)
            w.rate = typed_rate;
        pending_rates.push_back(w);
        if (gap > 0)
        begin
            frame_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering and wait for every outstanding rate word, then let the divider settle
    task automatic wait_idle();
        int spins;
        spins = 0;
        frame_if.valid <= 1'b0;
        while (pending_rates.size() != 0 && spins < DRAIN_LIMIT)
        begin
            @(posedge clk);
            spins++;
        end
        if (pending_rates.size() != 0)
        begin
            $error("%0d rate words never arrived", pending_rates.size());
            errors++;
            pending_rates.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // apb write: setup phase, access phase held until pready, then back to idle
    task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (addr == ADDR_TPS)
            tps_now = data[TPS_W-1:0];
    endtask

    // apb read of the tick rate register, compared with the model copy
    task automatic check_tps_readback();
        logic [CFG_DATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_TPS;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (got !== CFG_DATA_W'(tps_now))
        begin
            $error("ticks_per_second readback mismatch: expected %0d, got %0d", tps_now, got);
            errors++;
        end
    endtask

    // new tick rate while idle; the spare address takes junk that must be ignored
    task automatic set_tps(input logic [CFG_DATA_W-1:0] value);
        wait_idle();
        apb_write(ADDR_SPARE, $urandom());
        apb_write(ADDR_TPS, value);
        check_tps_readback();
    endtask

    // random bursts of durations with a common character per burst
    task automatic run_bursts(input int count);
        int                 sent;
        int                 mode;
        int                 len;
        int                 gap;
        int                 r;
        bit                 calm;
        longint             base;
        longint             jitter;
        longint             v;
        logic [FRAME_W-1:0] t;
        sent = 0;
        while (sent < count)
        begin
            mode   = $urandom_range(0, 9);
            len    = (mode == 0) ? $urandom_range(WINDOW_DEPTH, WINDOW_DEPTH + 16)
                                 : $urandom_range(1, 40);
            calm   = ($urandom_range(0, 3) == 0);
            base   = longint'(tps_now) / 60;
            jitter = base / 8;
            for (int k = 0; k < len; k++)
            begin
                case (mode)
                    0:       t = '0;
                    1, 2:    t = FRAME_W'($urandom_range(0, 255));
                    3, 4:    t = FRAME_W'($urandom());
                    5, 6, 7:
                    begin
                        // frame times near the nominal 60 Hz period of this tick rate
                        v = base - jitter + longint'($urandom_range(0, 2 * jitter));
                        t = (v > longint'(24'hFFFFFF)) ? 24'hFFFFFF : FRAME_W'(v);
                    end
                    8:       t = ($urandom_range(0, 1) == 1) ? 24'hFFFFFF
                                                             : FRAME_W'($urandom_range(0, 1));
                    default: t = FRAME_W'($urandom_range(0, 65535));
                endcase
                r   = $urandom_range(0, 99);
                gap = calm ? 0 : (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3)
                                                        : $urandom_range(10, 60);
                send_frame(t, 1'b0, '0, gap);
            end
            sent += len;
            if ($urandom_range(0, 19) == 0)
                wait_idle();
        end
    endtask

    // result side: random stalls, calm stretches and a long hold every so often
    initial
    begin
        int hold_left;
        int calm_left;
        int taken;
        int next_long;
        int r;
        hold_left = 0;
        calm_left = 0;
        taken     = 0;
        next_long = 150;
        rate_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rate_if.valid && rate_if.ready)
                taken++;
            if (!rst_n)
                rate_if.ready <= 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                rate_if.ready <= 1'b0;
            end
            else if (taken >= next_long)
            begin
                hold_left = LONG_HOLD;
                next_long += 500;
                rate_if.ready <= 1'b0;
            end
            else if (calm_left > 0)
            begin
                calm_left--;
                rate_if.ready <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                begin
                    calm_left = $urandom_range(50, 300);
                    rate_if.ready <= 1'b1;
                end
                else if (r < 70)
                    rate_if.ready <= 1'b1;
                else if (r < 95)
                begin
                    hold_left = $urandom_range(0, 2);
                    rate_if.ready <= 1'b0;
                end
                else
                begin
                    hold_left = $urandom_range(20, 80);
                    rate_if.ready <= 1'b0;
                end
            end
        end
    end

    // compare each rate word taken with the oldest expectation
    initial
    begin
        rate_word_t w;
        forever
        begin
            @(posedge clk);
            if (rst_n && rate_if.valid && rate_if.ready)
            begin
                if (pending_rates.size() == 0)
                begin
                    $error("unexpected rate word: frame_rate %0d, frame_count %0d",
                           rate_if.frame_rate, rate_if.frame_count);
                    errors++;
                end
                else
                begin
                    w = pending_rates.pop_front();
                    if (rate_if.frame_rate !== w.rate)
                    begin
                        $error("frame_rate mismatch: expected %0d, got %0d",
                               w.rate, rate_if.frame_rate);
                        errors++;
                    end
                    if (rate_if.frame_count !== w.count)
                    begin
                        $error("frame_count mismatch: expected %0d, got %0d",
                               w.count, rate_if.frame_count);
                        errors++;
                    end
                end
            end
        end
    end

    // run limit
    initial
    begin
        #(20_000_000);
        $display("TB_ERROR");
        $finish;
    end

    // reset, directed table, then one random phase per tick rate
    initial
    begin
        rst_n                <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        frame_if.valid       <= 1'b0;
        frame_if.frame_ticks <= '0;
        foreach (dur_ring[i])
            dur_ring[i] = '0;
        ring_total  = '0;
        ring_slot   = 0;
        frames_done = '0;
        tps_now     = TPS_RESET;
        tps_plan[4] = $urandom_range(1, 1000000000);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_tps_readback();

        foreach (directed_rows[i])
            send_frame(directed_rows[i].ticks, directed_rows[i].typed,
                       directed_rows[i].rate, $urandom_range(0, 2));

        foreach (tps_plan[i])
        begin
            set_tps(tps_plan[i]);
            run_bursts(ITEMS_PER_PHASE);
        end
        wait_idle();

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
